@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the radix digit writer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ sv/sitrd_pkg.sv @@
// ----------------------------------------------------------------------------
// sitrd_pkg
// Widths, codes, shared types and the symbol table lookup of the digit writer.
// ----------------------------------------------------------------------------
package sitrd_pkg;

    localparam int VALUE_W    = 32;
    localparam int SYM_W      = 8;
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 5;
    localparam int MAX_BASE   = 16;
    localparam int MAX_DIGITS = 32;
    localparam int COUNT_W    = 6;
    localparam int BIT_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Last bit position of one serial division pass.
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_W - 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    // Reserved sign characters.
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

    // Reset contents of the configuration registers.
    localparam logic [RADIX_W-1:0]    BASE_SIZE_RST    = 5'd10;
    localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0000000000003938;

    // Request from the sequencer to the serial divider.
    typedef struct packed {
        logic               load;
        logic [VALUE_W-1:0] value;
    } div_req_t;

    // Status from the serial divider: one remainder per finished pass.
    typedef struct packed {
        logic               digit_valid;
        logic               last;
        logic [DIGIT_W-1:0] digit;
    } div_stat_t;

    // Symbol idx of the table formed by both symbol registers.
    function automatic logic [SYM_W-1:0] symbol_at(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [DIGIT_W-1:0]    idx
    );
        logic [2*CFG_DATA_W-1:0] tab;
        tab = {hi, lo};
        return tab[idx*SYM_W +: SYM_W];
    endfunction

endpackage

@@ sv/sitrd_div.sv @@
// ----------------------------------------------------------------------------
// sitrd_div
// Bit-serial restoring divider that splits a magnitude into radix digits.
// ----------------------------------------------------------------------------
module sitrd_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sitrd_pkg::div_req_t              req,
    input  logic [sitrd_pkg::RADIX_W-1:0]    radix,
    output sitrd_pkg::div_stat_t             stat
);

    logic [sitrd_pkg::VALUE_W-1:0]   mag_reg, mag_next;
    logic [sitrd_pkg::DIGIT_W-1:0]   rem_reg, rem_next;
    logic [sitrd_pkg::BIT_CNT_W-1:0] bit_reg, bit_next;
    logic                            run_reg, run_next;
    logic                            qany_reg, qany_next;

    logic [sitrd_pkg::RADIX_W-1:0] trial;
    logic [sitrd_pkg::RADIX_W-1:0] diff;
    logic                          qbit;
    logic [sitrd_pkg::DIGIT_W-1:0] rem_step;
    logic                          pass_end;

    // One quotient bit per cycle: bring down the top magnitude bit.
    always_comb
    begin
        trial    = {rem_reg, mag_reg[sitrd_pkg::VALUE_W-1]};
        diff     = trial - radix;
        qbit     = (trial >= radix);
        rem_step = qbit ? diff[sitrd_pkg::DIGIT_W-1:0] : trial[sitrd_pkg::DIGIT_W-1:0];
        pass_end = run_reg && (bit_reg == sitrd_pkg::BIT_LAST);
    end

    // Pass sequencing; the quotient replaces the magnitude in place.
    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        run_next  = run_reg;
        qany_next = qany_reg;
        if (req.load)
        begin
            mag_next  = req.value;
            rem_next  = '0;
            bit_next  = '0;
            run_next  = 1'b1;
            qany_next = 1'b0;
        end
        else if (run_reg)
        begin
            mag_next  = {mag_reg[sitrd_pkg::VALUE_W-2:0], qbit};
            rem_next  = rem_step;
            bit_next  = bit_reg + 1'b1;
            qany_next = qany_reg | qbit;
            if (pass_end)
            begin
                rem_next  = '0;
                bit_next  = '0;
                qany_next = 1'b0;
                run_next  = qany_reg | qbit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            bit_reg  <= '0;
            qany_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            bit_reg  <= bit_next;
            qany_reg <= qany_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
    end

    // The remainder of a finished pass is the next digit, least significant first.
    always_comb
    begin
        stat.digit_valid = pass_end;
        stat.last        = !(qany_reg | qbit);
        stat.digit       = rem_step;
    end

endmodule

@@ sv/signed_integer_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits
// Writes a signed 32-bit value as symbol bytes in a configured radix.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------
//  request  | start, busy               | value
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//  result   | strobe (one cycle each)   | symbol, is_last
//
//  A request first checks the base symbols one at a time, then runs the
//  bit-serial divider (one quotient bit per cycle) once per digit, then
//  emits the sign byte and the digit bytes, most significant digit first.
//  An invalid base or symbol table ends the request with no bytes.
//  Reset is asynchronous and active low; results cannot be stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_integer_to_radix_digits (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sitrd_pkg::VALUE_W-1:0] value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sitrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sitrd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                strobe,
    output logic [sitrd_pkg::SYM_W-1:0]         symbol,
    output logic                                is_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]                        state_reg, state_next;
    logic [sitrd_pkg::RADIX_W-1:0]     base_size_reg;
    logic [sitrd_pkg::CFG_DATA_W-1:0]  symbols_low_reg;
    logic [sitrd_pkg::CFG_DATA_W-1:0]  symbols_high_reg;
    logic [sitrd_pkg::VALUE_W-1:0]     mag_reg, mag_next;
    logic                              neg_reg, neg_next;
    logic [sitrd_pkg::DIGIT_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [sitrd_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [sitrd_pkg::DIGIT_W-1:0]     stack_reg [sitrd_pkg::MAX_DIGITS];
    logic                              strobe_reg, strobe_next;
    logic [sitrd_pkg::SYM_W-1:0]       symbol_reg, symbol_next;
    logic                              is_last_reg, is_last_next;

    logic [sitrd_pkg::RADIX_W-1:0] radix;
    logic [sitrd_pkg::DIGIT_W-1:0] radix_top;
    logic [sitrd_pkg::SYM_W-1:0]   chk_sym;
    logic                          chk_bad;
    logic                          accept;
    logic                          push;
    logic                          pop;
    sitrd_pkg::div_req_t           dreq;
    sitrd_pkg::div_stat_t          dstat;

    // Configuration registers; writes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg    <= sitrd_pkg::BASE_SIZE_RST;
            symbols_low_reg  <= sitrd_pkg::SYMBOLS_LOW_RST;
            symbols_high_reg <= sitrd_pkg::SYMBOLS_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sitrd_pkg::REG_BASE_SIZE:
                    base_size_reg <= cfg_data[sitrd_pkg::RADIX_W-1:0];
                sitrd_pkg::REG_SYMBOLS_LOW:
                    symbols_low_reg <= cfg_data;
                sitrd_pkg::REG_SYMBOLS_HIGH:
                    symbols_high_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // Radix in use, capped at the table size.
    always_comb
    begin
        if (base_size_reg > sitrd_pkg::RADIX_W'(sitrd_pkg::MAX_BASE))
            radix = sitrd_pkg::RADIX_W'(sitrd_pkg::MAX_BASE);
        else
            radix = base_size_reg;
        radix_top = sitrd_pkg::DIGIT_W'(radix - 1'b1);
    end

    // Base check: one symbol per cycle against the sign characters and all
    // symbols below it.
    always_comb
    begin
        chk_sym = sitrd_pkg::symbol_at(symbols_low_reg, symbols_high_reg, chk_idx_reg);
        chk_bad = (chk_sym == sitrd_pkg::SYM_PLUS) || (chk_sym == sitrd_pkg::SYM_MINUS);
        for (int j = 0; j < sitrd_pkg::MAX_BASE; j++)
        begin
            if ((sitrd_pkg::DIGIT_W'(j) < chk_idx_reg) &&
                (sitrd_pkg::symbol_at(symbols_low_reg, symbols_high_reg,
                                      sitrd_pkg::DIGIT_W'(j)) == chk_sym))
                chk_bad = 1'b1;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        chk_idx_next = chk_idx_reg;
        count_next   = count_reg;
        strobe_next  = 1'b0;
        symbol_next  = symbol_reg;
        is_last_next = is_last_reg;
        push         = 1'b0;
        pop          = 1'b0;
        dreq.load    = 1'b0;
        dreq.value   = mag_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (radix >= sitrd_pkg::RADIX_W'(2)))
                begin
                    neg_next     = value[sitrd_pkg::VALUE_W-1];
                    mag_next     = value[sitrd_pkg::VALUE_W-1] ? -value : value;
                    chk_idx_next = '0;
                    count_next   = '0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (chk_bad)
                    state_next = ST_IDLE;
                else if (chk_idx_reg == radix_top)
                begin
                    dreq.load  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                    chk_idx_next = chk_idx_reg + 1'b1;
            end
            ST_DIV:
            begin
                if (dstat.digit_valid)
                begin
                    if (count_reg < sitrd_pkg::COUNT_W'(sitrd_pkg::MAX_DIGITS))
                    begin
                        push       = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (dstat.last)
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                if (neg_reg)
                begin
                    symbol_next  = sitrd_pkg::SYM_MINUS;
                    is_last_next = 1'b0;
                    neg_next     = 1'b0;
                end
                else
                begin
                    pop          = 1'b1;
                    symbol_next  = sitrd_pkg::symbol_at(symbols_low_reg, symbols_high_reg,
                                                        stack_reg[0]);
                    is_last_next = (count_reg == sitrd_pkg::COUNT_W'(1));
                    count_next   = count_reg - 1'b1;
                    if (count_reg == sitrd_pkg::COUNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            neg_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            neg_reg    <= neg_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        chk_idx_reg <= chk_idx_next;
        symbol_reg  <= symbol_next;
        is_last_reg <= is_last_next;
    end

    // Digit stack as a shift line: push enters at the top, pop shifts up.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg[0] <= dstat.digit;
            for (int k = 1; k < sitrd_pkg::MAX_DIGITS; k++)
                stack_reg[k] <= stack_reg[k-1];
        end
        else if (pop)
        begin
            for (int k = 0; k < sitrd_pkg::MAX_DIGITS - 1; k++)
                stack_reg[k] <= stack_reg[k+1];
        end
    end

    sitrd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .radix (radix),
        .stat  (dstat)
    );

    assign strobe  = strobe_reg;
    assign symbol  = symbol_reg;
    assign is_last = is_last_reg;

    // The final byte leaves the sequencer free for the next request.
    `ASSERT_IMPLIES(a_last_frees, clk, rst_n, strobe && is_last, !busy)
    // Emitting always has a digit left on the stack.
    `ASSERT_IMPLIES(a_emit_has_digit, clk, rst_n, state_reg == ST_EMIT, count_reg != '0)
    // The divider only reports digits while a division is in progress.
    `ASSERT_IMPLIES(a_digit_in_div, clk, rst_n, dstat.digit_valid, state_reg == ST_DIV)
    // A byte that is not the last is always followed by another byte.
    `ASSERT_NEXT(a_run_continues, clk, rst_n, strobe && !is_last, strobe)

endmodule

@@ tb/sv/signed_integer_to_radix_digits_tb.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_tb
// Self-checking bench for the radix digit writer. Directed requests cover the
// reset decimal table, the smallest and largest radix, an oversized base size
// and every kind of invalid table. Random phases then program random symbol
// tables and send bursts of values. Every byte is checked against an
// in-bench prediction of the sign, digit and last-byte sequence.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits_tb;

    import sitrd_pkg::*;

    // Register index that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One predicted output byte.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } out_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [VALUE_W-1:0]    value;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  strobe;
    logic [SYM_W-1:0]      symbol;
    logic                  is_last;

    // Bench copy of the configuration registers.
    logic [RADIX_W-1:0]    base_size_m;
    logic [CFG_DATA_W-1:0] table_lo_m;
    logic [CFG_DATA_W-1:0] table_hi_m;

    // Bytes still owed by the block, oldest first.
    out_byte_t pending_bytes[$];

    int error_count;
    int values_sent;
    int values_spelled;
    int bytes_checked;
    int tables_used;

    signed_integer_to_radix_digits dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .symbol    (symbol),
        .is_last   (is_last)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d bytes still expected", pending_bytes.size());
        $display("Some tests failed");
        $finish;
    end

    // Look up one digit in the programmed symbol table.
    function automatic logic [SYM_W-1:0] table_symbol(int unsigned digit);
        if (digit < 8)
            return SYM_W'(table_lo_m >> (8 * digit));
        return SYM_W'(table_hi_m >> (8 * (digit - 8)));
    endfunction

    // Radix in use, with an oversized base size clamped.
    function automatic int unsigned radix_now();
        if (base_size_m > MAX_BASE)
            return MAX_BASE;
        return 32'(base_size_m);
    endfunction

    // A table is usable with at least two symbols, all distinct, and no sign characters.
    function automatic bit table_ok(int unsigned radix);
        logic [SYM_W-1:0] s;
        if (radix < 2)
            return 1'b0;
        for (int i = 0; i < radix; i++)
        begin
            s = table_symbol(i);
            if (s == SYM_PLUS || s == SYM_MINUS)
                return 1'b0;
            for (int j = i + 1; j < radix; j++)
                if (table_symbol(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Predict the bytes for one value and queue them.
    function automatic void spell_value(logic [VALUE_W-1:0] v);
        int unsigned radix;
        logic [VALUE_W:0] mag;
        int unsigned digits[$];
        out_byte_t b;
        radix = radix_now();
        if (!table_ok(radix))
            return;
        values_spelled++;
        mag = v[VALUE_W-1] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
        do
        begin
            digits.push_back(int'(mag % radix));
            mag = mag / radix;
        end
        while (mag != 0);
        if (v[VALUE_W-1])
        begin
            b.sym  = SYM_MINUS;
            b.last = 1'b0;
            pending_bytes.push_back(b);
        end
        for (int k = digits.size() - 1; k >= 0; k--)
        begin
            b.sym  = table_symbol(digits[k]);
            b.last = (k == 0);
            pending_bytes.push_back(b);
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Send one request. Called at a falling edge; start is left high on return.
    task automatic send_value(logic [VALUE_W-1:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        spell_value(v);
        values_sent++;
        @(negedge clk);
    endtask

    // Sender gap: start is dropped for the given number of cycles.
    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Hold off requests until every byte is in and the block is idle.
    task automatic drain();
        start <= 1'b0;
        while (pending_bytes.size() != 0 || busy)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register. Called at a falling edge; valid is left high on return.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_BASE_SIZE:    base_size_m = data[RADIX_W-1:0];
            REG_SYMBOLS_LOW:  table_lo_m  = data;
            REG_SYMBOLS_HIGH: table_hi_m  = data;
            default:          ;
        endcase
        @(negedge clk);
    endtask

    // Program a full table once the block is idle.
    task automatic configure(logic [RADIX_W-1:0] base, logic [CFG_DATA_W-1:0] lo,
                             logic [CFG_DATA_W-1:0] hi);
        drain();
        write_reg(REG_BASE_SIZE, CFG_DATA_W'(base));
        write_reg(REG_SYMBOLS_LOW, lo);
        write_reg(REG_SYMBOLS_HIGH, hi);
        cfg_valid <= 1'b0;
        tables_used++;
    endtask

    // Random values, small values near zero, values at the edges and on powers of the current radix.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] edges[6];
        longint p;
        int unsigned radix;
        logic [VALUE_W-1:0] v;
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h8000_0001};
        radix = (radix_now() < 2) ? 2 : radix_now();
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = VALUE_W'($urandom_range(0, 200)) - 32'd100;
            2: v = edges[$urandom_range(0, 5)];
            default:
            begin
                p = 1;
                repeat ($urandom_range(0, 31))
                    if (p * radix <= 64'h8000_0000)
                        p = p * radix;
                v = VALUE_W'(p - $urandom_range(0, 1));
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // Compare each strobed byte with the oldest prediction.
    always @(posedge clk)
    begin
        out_byte_t want;
        if (rst_n && strobe)
        begin
            bytes_checked++;
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte 0x%02h", symbol));
            else
            begin
                want = pending_bytes.pop_front();
                if (symbol !== want.sym)
                    report_mismatch($sformatf("symbol 0x%02h, expected 0x%02h",
                                              symbol, want.sym));
                if (is_last !== want.last)
                    report_mismatch($sformatf("is_last %b, expected %b on symbol 0x%02h",
                                              is_last, want.last, want.sym));
            end
        end
    end

    // Decimal output with the reset table.
    task automatic test_reset_table();
        logic [VALUE_W-1:0] vals[8];
        vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'd10,
                 32'h7FFF_FFFF, 32'h8000_0000};
        foreach (vals[i])
        begin
            if (i == 4)
                pause_sender(3);
            send_value(vals[i]);
        end
    endtask

    // Smallest and largest radix, zero and all-ones bytes as symbols, oversized size.
    task automatic test_radix_extremes();
        configure(5'd2, 64'hFFFF_FFFF_FFFF_3130, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd5);
        configure(5'd16, 64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988);
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);
        send_value(32'h1234_5678);
        send_value(32'h8000_0000);
        configure(5'd31, 64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988);
        send_value(32'hDEAD_BEEF);
        send_value(32'd255);
    endtask

    // Tables that must give no bytes, sign characters beyond the radix, unknown index.
    task automatic test_invalid_tables();
        configure(5'd0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(32'd5);
        configure(5'd1, SYMBOLS_LOW_RST, SYMBOLS_HIGH_RST);
        send_value(32'd7);
        configure(5'd10, 64'h3736_3534_3332_3030, SYMBOLS_HIGH_RST);
        send_value(32'd3);
        configure(5'd10, 64'h3736_3534_332B_3130, SYMBOLS_HIGH_RST);
        send_value(-32'd4);
        configure(5'd10, SYMBOLS_LOW_RST, 64'h0000_0000_0000_2D38);
        send_value(32'd12);
        configure(5'd2, 64'h2D2D_2B2B_2D2B_7A79, 64'h2B2B_2B2B_2D2D_2D2D);
        send_value(-32'd7);
        drain();
        write_reg(REG_UNUSED, 64'h0);
        cfg_valid <= 1'b0;
        send_value(32'd42);
    endtask

    // Random tables and values, sent in bursts.
    task automatic test_random(int target);
        logic [2*CFG_DATA_W-1:0] tab;
        logic [RADIX_W-1:0] base;
        bit used[256];
        logic [SYM_W-1:0] b;
        int unsigned radix;
        int i, j;
        int n;
        int burst_left;
        int phase;
        int start_spelled;
        start_spelled = values_spelled;
        burst_left = 0;
        phase = 0;
        while (values_spelled - start_spelled < target)
        begin
            // Sixteen distinct symbols, none of them a sign character.
            foreach (used[k])
                used[k] = 0;
            for (int k = 0; k < 16; k++)
            begin
                do
                    b = SYM_W'($urandom_range(0, 255));
                while (used[b] || b == SYM_PLUS || b == SYM_MINUS);
                used[b] = 1;
                tab[8*k +: 8] = b;
            end
            base = ($urandom_range(0, 9) == 0) ? RADIX_W'($urandom_range(17, 31))
                                               : RADIX_W'($urandom_range(2, 16));
            radix = (base > MAX_BASE) ? MAX_BASE : base;
            // Now and then spoil the table.
            if (phase > 0 && $urandom_range(0, 7) == 0)
            begin
                i = $urandom_range(0, radix - 1);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        j = (i + $urandom_range(1, radix - 1)) % radix;
                        tab[8*j +: 8] = tab[8*i +: 8];
                    end
                    1: tab[8*i +: 8] = $urandom_range(0, 1) ? SYM_PLUS : SYM_MINUS;
                    default: base = RADIX_W'($urandom_range(0, 1));
                endcase
            end
            configure(base, tab[CFG_DATA_W-1:0], tab[2*CFG_DATA_W-1:CFG_DATA_W]);
            n = $urandom_range(8, 20);
            for (int k = 0; k < n; k++)
            begin
                if (phase == 1 && k == n / 2)
                    drain();
                if (burst_left == 0)
                begin
                    pause_sender($urandom_range(1, 12));
                    burst_left = ($urandom_range(0, 3) == 0) ? 25 : $urandom_range(1, 6);
                end
                burst_left--;
                send_value(pick_value());
            end
            phase++;
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        value       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_BASE_SIZE;
        cfg_data    = '0;
        base_size_m = BASE_SIZE_RST;
        table_lo_m  = SYMBOLS_LOW_RST;
        table_hi_m  = SYMBOLS_HIGH_RST;
        error_count    = 0;
        values_sent    = 0;
        values_spelled = 0;
        bytes_checked  = 0;
        tables_used    = 1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_table();
        test_radix_extremes();
        test_invalid_tables();
        test_random(100);
        drain();

        $display("Covered %0d requests over %0d symbol tables, %0d of them with output.",
                 values_sent, tables_used, values_spelled);
        $display("Checked %0d bytes for radix 2 to 16, oversized and invalid tables.",
                 bytes_checked);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
